FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the line editor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define TLE_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define TLE_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define TLE_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: rtl/core/tle_pkg.sv
package tle_pkg;

	localparam int BYTE_W         = 8;
	localparam int MAP_W          = 3;
	localparam int MODE_W         = 4;
	localparam int LIMIT_W        = 7;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 7;
	localparam int LINE_DEPTH_DEF = 64;

	localparam logic [CFG_IDX_W-1:0] REG_INPUT_MAP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_MODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_READ_LIMIT = 2'd2;

	localparam logic [MAP_W-1:0]   MAP_RESET   = 3'd0;
	localparam logic [MODE_W-1:0]  MODE_RESET  = 4'd1;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

	localparam int MAP_IGNCR  = 0;
	localparam int MAP_ICRNL  = 1;
	localparam int MAP_INLCR  = 2;
	localparam int MODE_ICANON = 0;
	localparam int MODE_ERASE  = 1;
	localparam int MODE_KILL   = 2;
	localparam int MODE_IEXTEN = 3;

	localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
	localparam logic [BYTE_W-1:0] CH_EOF    = 8'h04;
	localparam logic [BYTE_W-1:0] CH_BS     = 8'h08;
	localparam logic [BYTE_W-1:0] CH_NL     = 8'h0a;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0d;
	localparam logic [BYTE_W-1:0] CH_KILL   = 8'h15;
	localparam logic [BYTE_W-1:0] CH_WERASE = 8'h17;
	localparam logic [BYTE_W-1:0] CH_US     = 8'h1f;
	localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [BYTE_W-1:0] CH_DEL    = 8'h7f;

endpackage

FILE: rtl/core/tle_if.sv
interface tle_rx_if;
	logic                       valid;
	logic                       ready;
	logic [tle_pkg::BYTE_W-1:0] rx_byte;
	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

interface tle_line_if;
	logic                       valid;
	logic                       ready;
	logic [tle_pkg::BYTE_W-1:0] line_byte;
	logic                       line_last;
	logic                       no_data;
	modport source(output valid, output line_byte, output line_last, output no_data,
		input ready);
	modport sink(input valid, input line_byte, input line_last, input no_data,
		output ready);
endinterface

interface tle_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [tle_pkg::CFG_IDX_W-1:0]  index;
	logic [tle_pkg::CFG_DATA_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/tty_canonical_line_editor.sv
// Canonical terminal line editor.
// Received bytes arrive one word at a time on the rx channel. Each byte is
// mapped (CR drop, CR to NL, NL to CR) and then edited into a line store held
// in a single-port-write, single-port-read synchronous memory.
// A normal byte is taken without holding off rx, unless it completes a read.
// Word erase walks back through the store, a read state and a check state per
// byte examined, with rx held off meanwhile.
// When a read completes, the line is sent on the line channel with line_last
// on its final word, each word read from the store and then loaded into the
// output register; an empty read gives one word with no_data set. Input is
// held off until the last word has been loaded into the output register.
// The first word of a full read is read in S_EMIT_RD and loaded in S_EMIT_LD;
// the word of an empty read is loaded in S_EMPTY once the output register is free.
// The output register decouples the receiver: a stall on line only holds the
// pending word and delays the next memory read.
// Configuration words on cfg are always taken at once.
// Reset clears the fill count, the output register and the configuration
// registers; the store contents are not cleared and need no clearing pass.
`include "assert_macros.svh"

module tty_canonical_line_editor #(
	parameter int LINE_DEPTH = tle_pkg::LINE_DEPTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	tle_rx_if.sink       rx,
	tle_line_if.source   line,
	tle_cfg_if.sink      cfg
);

	localparam int AW = $clog2(LINE_DEPTH);
	localparam int FW = $clog2(LINE_DEPTH + 1);
	localparam int CW = (FW > tle_pkg::LIMIT_W) ? FW : tle_pkg::LIMIT_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WE_RD,
		S_WE_CHK,
		S_CHK,
		S_EMIT_RD,
		S_EMIT_LD,
		S_EMPTY
	} state_t;

	state_t                             state_q;
	logic [FW-1:0]                      fill_q;
	logic [AW-1:0]                      idx_q;
	logic                               phase_q;
	logic                               out_vld_q;
	logic [tle_pkg::BYTE_W-1:0]         out_byte_q;
	logic                               out_last_q;
	logic                               out_nodata_q;
	logic [tle_pkg::MAP_W-1:0]          map_q;
	logic [tle_pkg::MODE_W-1:0]         mode_q;
	logic [tle_pkg::LIMIT_W-1:0]        limit_q;

	logic [tle_pkg::BYTE_W-1:0] mem [LINE_DEPTH];
	logic [tle_pkg::BYTE_W-1:0] rdata_q;

	logic [tle_pkg::BYTE_W-1:0] ch_c;
	logic                       drop_c;
	logic                       store_c;
	logic                       erase_c;
	logic                       kill_c;
	logic                       werase_c;
	logic                       ender_c;
	logic                       full_c;
	logic [FW-1:0]              fill_nxt_c;
	logic [FW-1:0]              fill_m1_c;
	logic [CW-1:0]              lim_c;
	logic                       done_c;
	logic                       fill_ge_c;
	logic                       out_free_c;
	logic                       last_c;
	logic                       in_acc_c;
	logic                       we_c;
	logic                       re_c;
	logic [AW-1:0]              raddr_c;

	assign rx.ready        = (state_q == S_IDLE);
	assign in_acc_c        = rx.valid && rx.ready;
	assign cfg.ready       = 1'b1;
	assign line.valid      = out_vld_q;
	assign line.line_byte  = out_byte_q;
	assign line.line_last  = out_last_q;
	assign line.no_data    = out_nodata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q   <= tle_pkg::MAP_RESET;
			mode_q  <= tle_pkg::MODE_RESET;
			limit_q <= tle_pkg::LIMIT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				tle_pkg::REG_INPUT_MAP:  map_q   <= cfg.data[tle_pkg::MAP_W-1:0];
				tle_pkg::REG_LOCAL_MODE: mode_q  <= cfg.data[tle_pkg::MODE_W-1:0];
				tle_pkg::REG_READ_LIMIT: limit_q <= cfg.data[tle_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		ch_c   = rx.rx_byte;
		drop_c = 1'b0;
		if (rx.rx_byte == tle_pkg::CH_CR) begin
			if (map_q[tle_pkg::MAP_IGNCR]) begin
				drop_c = 1'b1;
			end else if (map_q[tle_pkg::MAP_ICRNL]) begin
				ch_c = tle_pkg::CH_NL;
			end
		end else if (rx.rx_byte == tle_pkg::CH_NL && map_q[tle_pkg::MAP_INLCR]) begin
			ch_c = tle_pkg::CH_CR;
		end
	end

	always_comb begin
		store_c  = 1'b0;
		erase_c  = 1'b0;
		kill_c   = 1'b0;
		werase_c = 1'b0;
		ender_c  = 1'b0;
		if (!mode_q[tle_pkg::MODE_ICANON]) begin
			store_c = 1'b1;
		end else begin
			unique case (ch_c)
				tle_pkg::CH_NL, tle_pkg::CH_NUL: begin
					store_c = 1'b1;
					ender_c = 1'b1;
				end
				tle_pkg::CH_EOF: begin
					ender_c = 1'b1;
				end
				tle_pkg::CH_BS, tle_pkg::CH_US, tle_pkg::CH_DEL: begin
					erase_c = mode_q[tle_pkg::MODE_ERASE];
					store_c = !mode_q[tle_pkg::MODE_ERASE];
				end
				tle_pkg::CH_KILL: begin
					kill_c  = mode_q[tle_pkg::MODE_KILL];
					store_c = !mode_q[tle_pkg::MODE_KILL];
				end
				tle_pkg::CH_WERASE: begin
					werase_c = mode_q[tle_pkg::MODE_ERASE] || mode_q[tle_pkg::MODE_IEXTEN];
					store_c  = !werase_c;
				end
				default: begin
					store_c = 1'b1;
				end
			endcase
		end
	end

	always_comb begin
		if (limit_q == '0) begin
			lim_c = CW'(1);
		end else if (CW'(limit_q) > CW'(LINE_DEPTH)) begin
			lim_c = CW'(LINE_DEPTH);
		end else begin
			lim_c = CW'(limit_q);
		end
	end

	assign full_c    = (fill_q == FW'(LINE_DEPTH));
	assign fill_m1_c = fill_q - FW'(1);

	always_comb begin
		priority if (kill_c) begin
			fill_nxt_c = '0;
		end else if (erase_c && fill_q != '0) begin
			fill_nxt_c = fill_m1_c;
		end else if (store_c && !full_c) begin
			fill_nxt_c = fill_q + FW'(1);
		end else begin
			fill_nxt_c = fill_q;
		end
	end

	assign done_c     = ender_c || (CW'(fill_nxt_c) >= lim_c);
	assign fill_ge_c  = (CW'(fill_q) >= lim_c);
	assign out_free_c = !out_vld_q || line.ready;
	assign last_c     = ((FW'(idx_q) + FW'(1)) == fill_q);

	assign we_c    = in_acc_c && !drop_c && store_c && !full_c;
	assign re_c    = (state_q == S_WE_RD && fill_q != '0) || (state_q == S_EMIT_RD && out_free_c);
	assign raddr_c = (state_q == S_EMIT_RD) ? idx_q : fill_m1_c[AW-1:0];

	always_ff @(posedge clk) begin
		if (we_c) begin
			mem[fill_q[AW-1:0]] <= ch_c;
		end
		if (re_c) begin
			rdata_q <= mem[raddr_c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fill_q       <= '0;
			idx_q        <= '0;
			phase_q      <= 1'b0;
			out_vld_q    <= 1'b0;
			out_byte_q   <= '0;
			out_last_q   <= 1'b0;
			out_nodata_q <= 1'b0;
		end else begin
			if (line.valid && line.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc_c && !drop_c) begin
						if (werase_c) begin
							phase_q <= 1'b0;
							state_q <= S_WE_RD;
						end else begin
							fill_q <= fill_nxt_c;
							if (done_c) begin
								idx_q   <= '0;
								state_q <= (fill_nxt_c == '0) ? S_EMPTY : S_EMIT_RD;
							end
						end
					end
				end
				S_WE_RD: begin
					state_q <= (fill_q == '0) ? S_CHK : S_WE_CHK;
				end
				S_WE_CHK: begin
					if (!phase_q) begin
						fill_q  <= fill_m1_c;
						phase_q <= (rdata_q != tle_pkg::CH_SPACE);
						state_q <= S_WE_RD;
					end else if (rdata_q != tle_pkg::CH_SPACE) begin
						fill_q  <= fill_m1_c;
						state_q <= S_WE_RD;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					idx_q   <= '0;
					state_q <= fill_ge_c ? S_EMIT_RD : S_IDLE;
				end
				S_EMIT_RD: begin
					if (out_free_c) begin
						state_q <= S_EMIT_LD;
					end
				end
				S_EMIT_LD: begin
					out_vld_q    <= 1'b1;
					out_byte_q   <= rdata_q;
					out_last_q   <= last_c;
					out_nodata_q <= 1'b0;
					idx_q        <= idx_q + AW'(1);
					if (last_c) begin
						fill_q  <= '0;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_EMIT_RD;
					end
				end
				S_EMPTY: begin
					if (!out_vld_q) begin
						out_vld_q    <= 1'b1;
						out_byte_q   <= '0;
						out_last_q   <= 1'b0;
						out_nodata_q <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`TLE_ASSERT_ALWAYS(a_fill_bound, clk, arst_n, fill_q <= FW'(LINE_DEPTH), "fill count beyond store depth")
	`TLE_ASSERT_IMPL(a_emit_in_line, clk, arst_n, state_q == S_EMIT_RD, FW'(idx_q) < fill_q, "emission index outside line")
	`TLE_ASSERT_NEXT(a_werase_shrinks, clk, arst_n, state_q == S_WE_CHK, fill_q <= $past(fill_q), "word erase grew the line")
	`TLE_ASSERT_NEXT(a_last_clears, clk, arst_n, state_q == S_EMIT_LD && last_c, fill_q == '0 && state_q == S_IDLE, "line not cleared after last word")

endmodule

FILE: sim/tty_canonical_line_editor_test.sv
module tty_canonical_line_editor_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tle_pkg::*;

	localparam int LINE_DEPTH = LINE_DEPTH_DEF;
	localparam int RANDOM_ITEMS = 260;
	localparam int SETTLE_CYCLES = 200;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DIRECTED_ROWS = 30;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
		logic              no_data;
	} line_word_t;

	typedef enum logic {STEP_BYTE, STEP_CFG} step_kind_t;

	typedef struct packed {
		step_kind_t            kind;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] value;
		logic [BYTE_W-1:0]     rx;
		logic                  typed;
		line_word_t            word;
	} script_row_t;

	typedef enum {PACE_FULL, PACE_LIGHT, PACE_HEAVY} sink_pace_t;

	logic clk;
	logic arst_n;

	tle_rx_if   rx();
	tle_line_if line();
	tle_cfg_if  cfg();

	tty_canonical_line_editor dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.line   (line),
		.cfg    (cfg)
	);

	// Mirror of the editor: configuration, line store and fill count.
	logic [MAP_W-1:0]   map_q;
	logic [MODE_W-1:0]  mode_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [BYTE_W-1:0]  line_q [LINE_DEPTH];
	int                 fill_q;

	line_word_t line_words_due[$];
	line_word_t fresh_words[$];
	line_word_t due_word;

	int mismatches;
	int bytes_sent;
	int directed_sent;
	int words_seen;
	int reads_done;
	int empty_reads;
	int settings_used;
	int cycle_count;
	int burst_left;
	int pace_left = 0;
	sink_pace_t pace = PACE_FULL;

	script_row_t directed_script [DIRECTED_ROWS] = '{
		'{STEP_BYTE, REG_INPUT_MAP, 7'd0, CH_EOF, 1'b1, {8'h00, 1'b0, 1'b1}},
		'{STEP_BYTE, REG_INPUT_MAP, 7'd0, CH_NL, 1'b1, {CH_NL, 1'b1, 1'b0}},
		'{STEP_BYTE, REG_INPUT_MAP, 7'd0, CH_NUL, 1'b1, {CH_NUL, 1'b1, 1'b0}},
		'{STEP_BYTE, REG_INPUT_MAP, 7'd0, 8'h41, 1'b0, '0},
		'{STEP_BYTE, REG_INPUT_MAP, 7'd0, CH_DEL, 1'b0, '0},
		'{STEP_BYTE, REG_INPUT_MAP, 7'd0, CH_BS, 1'b0, '0},
		'{STEP_BYTE, REG_INPUT_MAP, 7'd0, CH_KILL, 1'b0, '0},
		'{STEP_BYTE, REG_INPUT_MAP, 7'd0, CH_WERASE, 1'b0, '0},
		'{STEP_BYTE, REG_INPUT_MAP, 7'd0, 8'hff, 1'b0, '0},
		'{STEP_BYTE, REG_INPUT_MAP, 7'd0, CH_EOF, 1'b0, '0},
		'{STEP_CFG, REG_INPUT_MAP, 7'd6, 8'h00, 1'b0, '0},
		'{STEP_CFG, REG_LOCAL_MODE, 7'd15, 8'h00, 1'b0, '0},
		'{STEP_BYTE, REG_INPUT_MAP, 7'd0, CH_BS, 1'b0, '0},
		'{STEP_BYTE, REG_INPUT_MAP, 7'd0, 8'h61, 1'b0, '0},
		'{STEP_BYTE, REG_INPUT_MAP, 7'd0, CH_SPACE, 1'b0, '0},
		'{STEP_BYTE, REG_INPUT_MAP, 7'd0, 8'h63, 1'b0, '0},
		'{STEP_BYTE, REG_INPUT_MAP, 7'd0, CH_SPACE, 1'b0, '0},
		'{STEP_BYTE, REG_INPUT_MAP, 7'd0, CH_WERASE, 1'b0, '0},
		'{STEP_BYTE, REG_INPUT_MAP, 7'd0, CH_US, 1'b0, '0},
		'{STEP_BYTE, REG_INPUT_MAP, 7'd0, CH_KILL, 1'b0, '0},
		'{STEP_BYTE, REG_INPUT_MAP, 7'd0, 8'h64, 1'b0, '0},
		'{STEP_BYTE, REG_INPUT_MAP, 7'd0, CH_CR, 1'b0, '0},
		'{STEP_BYTE, REG_INPUT_MAP, 7'd0, CH_NL, 1'b0, '0},
		'{STEP_BYTE, REG_INPUT_MAP, 7'd0, CH_EOF, 1'b0, '0},
		'{STEP_CFG, REG_INPUT_MAP, 7'd7, 8'h00, 1'b0, '0},
		'{STEP_CFG, REG_LOCAL_MODE, 7'd0, 8'h00, 1'b0, '0},
		'{STEP_CFG, REG_READ_LIMIT, 7'd1, 8'h00, 1'b0, '0},
		'{STEP_BYTE, REG_INPUT_MAP, 7'd0, CH_NL, 1'b1, {CH_CR, 1'b1, 1'b0}},
		'{STEP_BYTE, REG_INPUT_MAP, 7'd0, CH_CR, 1'b0, '0},
		'{STEP_BYTE, REG_INPUT_MAP, 7'd0, CH_NUL, 1'b1, {CH_NUL, 1'b1, 1'b0}}
	};

	function automatic void keep_byte(logic [BYTE_W-1:0] c);
		if (fill_q < LINE_DEPTH) begin
			line_q[fill_q] = c;
			fill_q++;
		end
	endfunction

	// Applies one received byte to the mirror and leaves the words of any
	// completed read in fresh_words.
	function automatic void edit_rx_byte(logic [BYTE_W-1:0] raw);
		logic [BYTE_W-1:0] c;
		logic              done;
		int                lim;
		int                k;
		c = raw;
		done = 1'b0;
		fresh_words.delete();
		if (c == CH_CR) begin
			if (map_q[MAP_IGNCR])
				return;
			if (map_q[MAP_ICRNL])
				c = CH_NL;
		end else if (c == CH_NL && map_q[MAP_INLCR]) begin
			c = CH_CR;
		end
		if (!mode_q[MODE_ICANON]) begin
			keep_byte(c);
		end else begin
			case (c)
			CH_NL, CH_NUL: begin
				keep_byte(c);
				done = 1'b1;
			end
			CH_EOF: begin
				done = 1'b1;
			end
			CH_BS, CH_US, CH_DEL: begin
				if (mode_q[MODE_ERASE]) begin
					if (fill_q > 0)
						fill_q--;
				end else begin
					keep_byte(c);
				end
			end
			CH_KILL: begin
				if (mode_q[MODE_KILL])
					fill_q = 0;
				else
					keep_byte(c);
			end
			CH_WERASE: begin
				if (mode_q[MODE_ERASE] || mode_q[MODE_IEXTEN]) begin
					while (fill_q > 0 && line_q[fill_q-1] == CH_SPACE)
						fill_q--;
					while (fill_q > 0 && line_q[fill_q-1] != CH_SPACE)
						fill_q--;
				end else begin
					keep_byte(c);
				end
			end
			default: begin
				keep_byte(c);
			end
			endcase
		end
		lim = int'(limit_q);
		if (lim == 0)
			lim = 1;
		if (lim > LINE_DEPTH)
			lim = LINE_DEPTH;
		if (fill_q >= lim)
			done = 1'b1;
		if (!done)
			return;
		if (fill_q == 0) begin
			fresh_words.push_back({8'h00, 1'b0, 1'b1});
		end else begin
			for (k = 0; k < fill_q; k++)
				fresh_words.push_back({line_q[k], k == fill_q - 1, 1'b0});
		end
		fill_q = 0;
	endfunction

	task automatic send_rx(input logic [BYTE_W-1:0] b, input logic typed,
		input line_word_t word);
		int gap;
		rx.valid <= 1'b1;
		rx.rx_byte <= b;
		do @(posedge clk); while (!rx.ready);
		edit_rx_byte(b);
		if (typed)
			line_words_due.push_back(word);
		else
			foreach (fresh_words[k])
				line_words_due.push_back(fresh_words[k]);
		bytes_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				rx.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		@(posedge clk);
		case (idx)
		REG_INPUT_MAP: map_q = value[MAP_W-1:0];
		REG_LOCAL_MODE: mode_q = value[MODE_W-1:0];
		REG_READ_LIMIT: limit_q = value[LIMIT_W-1:0];
		default: ;
		endcase
	endtask

	// Waits until every expected word has arrived and any word erase has had
	// time to finish walking the store.
	task automatic settle_block();
		rx.valid <= 1'b0;
		while (line_words_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out with %0d line words outstanding.", line_words_due.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (pace_left == 0) begin
			pace_left <= $urandom_range(20, 120);
			pace <= sink_pace_t'($urandom_range(0, 2));
		end else begin
			pace_left <= pace_left - 1;
		end
		case (pace)
		PACE_FULL: line.ready <= 1'b1;
		PACE_LIGHT: line.ready <= ($urandom_range(0, 3) != 0);
		default: line.ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && line.valid && line.ready) begin
			words_seen++;
			if (line.line_last || line.no_data)
				reads_done++;
			if (line.no_data)
				empty_reads++;
			if (line_words_due.size() == 0) begin
				if (mismatches < 10)
					$display("Unexpected line word: byte %h last %b no_data %b",
						line.line_byte, line.line_last, line.no_data);
				mismatches++;
			end else begin
				due_word = line_words_due.pop_front();
				if (line.line_byte !== due_word.data || line.line_last !== due_word.last
					|| line.no_data !== due_word.no_data) begin
					if (mismatches < 10)
						$display("Line word mismatch: expected byte %h last %b no_data %b,",
							due_word.data, due_word.last, due_word.no_data,
							" got byte %h last %b no_data %b",
							line.line_byte, line.line_last, line.no_data);
					mismatches++;
				end
			end
		end
	end

	initial begin
		script_row_t       row;
		logic              idle;
		logic [BYTE_W-1:0] b;
		logic [MAP_W-1:0]  new_map;
		logic [MODE_W-1:0] new_mode;
		int                new_limit;
		int                count;
		int                pick;
		int                phase;
		int                random_sent;
		arst_n = 1'b0;
		rx.valid = 1'b0;
		rx.rx_byte = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		burst_left = 0;
		map_q = MAP_RESET;
		mode_q = MODE_RESET;
		limit_q = LIMIT_RESET;
		fill_q = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle = 1'b1;
		foreach (directed_script[r]) begin
			row = directed_script[r];
			if (row.kind == STEP_CFG) begin
				if (!idle)
					settle_block();
				idle = 1'b1;
				write_reg(row.index, row.value);
			end else begin
				idle = 1'b0;
				send_rx(row.rx, row.typed, row.word);
			end
		end
		directed_sent = bytes_sent;
		settings_used = 3;

		phase = 0;
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			if (phase == 0) begin
				new_map = 3'd7;
				new_mode = 4'd0;
				new_limit = LINE_DEPTH;
				count = 70;
			end else if (phase == 1) begin
				new_map = 3'd0;
				new_mode = 4'd15;
				new_limit = 1;
				count = 20;
			end else begin
				new_map = MAP_W'($urandom_range(0, 7));
				new_mode = MODE_W'($urandom_range(0, 15));
				if ($urandom_range(0, 3) != 0)
					new_mode[MODE_ICANON] = 1'b1;
				new_limit = ($urandom_range(0, 4) == 0) ? LINE_DEPTH : $urandom_range(2, 20);
				count = $urandom_range(15, 35);
			end
			settle_block();
			write_reg(REG_INPUT_MAP, CFG_DATA_W'(new_map));
			write_reg(REG_LOCAL_MODE, CFG_DATA_W'(new_mode));
			write_reg(REG_READ_LIMIT, CFG_DATA_W'(new_limit));
			settings_used++;
			repeat (count) begin
				pick = $urandom_range(0, 99);
				if (pick < 50) begin
					b = BYTE_W'($urandom_range(8'h21, 8'h7e));
				end else if (pick < 64) begin
					b = CH_SPACE;
				end else if (pick < 76) begin
					case ($urandom_range(0, 4))
					0: b = CH_BS;
					1: b = CH_US;
					2: b = CH_DEL;
					3: b = CH_KILL;
					default: b = CH_WERASE;
					endcase
				end else if (pick < 86) begin
					case ($urandom_range(0, 3))
					0: b = CH_NL;
					1: b = CH_NUL;
					2: b = CH_EOF;
					default: b = CH_CR;
					endcase
				end else begin
					b = BYTE_W'($urandom_range(0, 255));
				end
				send_rx(b, 1'b0, '0);
				random_sent++;
			end
			phase++;
		end

		settle_block();
		$display("Sent %0d received bytes (%0d directed) under %0d register settings.",
			bytes_sent, directed_sent, settings_used);
		$display("Checked %0d line words closing %0d reads, %0d of them empty.",
			words_seen, reads_done, empty_reads);
		if (mismatches == 0 && line_words_due.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches found.", mismatches);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
